### src/lpts_pkg.sv
// shared types and codes for the two-priority lifo task scheduler
`default_nettype none
package lpts_pkg;

    // operation codes
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // priority classes
    localparam logic PRI_URGENT     = 1'b0;
    localparam logic PRI_BACKGROUND = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_BUSY     = 2'd2;
    localparam logic [1:0] ST_IDLE     = 2'd3;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_stk_stat;

endpackage
`default_nettype wire

### src/two_priority_lifo_task_scheduler_top.sv
// top level of the two-priority lifo task scheduler
//
//  channel   | handshake             | signals
//  ----------+-----------------------+-----------------------------------------------
//  command   | start && !busy        | i_operation i_task_id i_priority_req i_duration
//  result    | o_valid (1-cycle)     | o_status o_running_id o_remaining o_finished
//            |                       | o_finished_id
//
//  arrive and ticks that need no pop: the result strobes on the next cycle
//  a tick that pops a task: waits in S_POP for the stack ram read data, then the result is registered
//  busy is high only in S_POP, while waiting for the ram read data
//  synchronous active-low reset empties both stacks and frees the processor
//  results cannot be stalled; o_valid flags each one for exactly one cycle
`default_nettype none
module two_priority_lifo_task_scheduler_top #(
    parameter int STACK_DEPTH   = 16,
    parameter int ID_BITS       = 8,
    parameter int DURATION_BITS = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     i_operation,
    input  wire logic [ID_BITS-1:0]       i_task_id,
    input  wire logic                     i_priority_req,
    input  wire logic [DURATION_BITS-1:0] i_duration,
    output logic                          o_valid,
    output logic      [1:0]               o_status,
    output logic      [ID_BITS-1:0]       o_running_id,
    output logic      [DURATION_BITS-1:0] o_remaining,
    output logic                          o_finished,
    output logic      [ID_BITS-1:0]       o_finished_id
);
    import lpts_pkg::*;

    localparam int EW = ID_BITS + DURATION_BITS;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic r_state;
    logic n_state;

    // processor state
    logic                     r_run;
    logic [ID_BITS-1:0]       r_cur_id;
    logic [DURATION_BITS-1:0] r_ticks;
    logic                     r_sel;

    logic accept;
    logic pop_now;
    logic tick_now;

    t_stk_cmd  urg_cmd;
    t_stk_cmd  bgd_cmd;
    t_stk_stat urg_stat;
    t_stk_stat bgd_stat;
    logic [EW-1:0] entry;
    logic [EW-1:0] urg_rdata;
    logic [EW-1:0] bgd_rdata;
    logic [EW-1:0] pop_data;

    logic                     t_run;
    logic [ID_BITS-1:0]       t_id;
    logic [DURATION_BITS-1:0] t_tl;
    logic                     n_run;
    logic [DURATION_BITS-1:0] n_tl;
    logic [1:0]               n_status;
    logic [ID_BITS-1:0]       n_running_id;
    logic [DURATION_BITS-1:0] n_remaining;
    logic                     n_finished;
    logic [ID_BITS-1:0]       n_finished_id;
    logic                     push_full;

    assign busy   = (r_state == S_POP);
    assign accept = start && !busy;
    assign entry  = {i_task_id, i_duration};

    assign pop_now = accept && (i_operation == OP_TICK) && !r_run
                     && !(urg_stat.empty && bgd_stat.empty);
    // tick work done this cycle: either directly or once the popped entry is back
    assign tick_now = (accept && (i_operation == OP_TICK) && !pop_now) || busy;

    assign push_full = (i_priority_req == PRI_URGENT) ? urg_stat.full : bgd_stat.full;

    always_comb begin
        urg_cmd.push = accept && (i_operation == OP_ARRIVE)
                       && (i_priority_req == PRI_URGENT) && !urg_stat.full;
        bgd_cmd.push = accept && (i_operation == OP_ARRIVE)
                       && (i_priority_req == PRI_BACKGROUND) && !bgd_stat.full;
        urg_cmd.pop  = pop_now && !urg_stat.empty;
        bgd_cmd.pop  = pop_now && urg_stat.empty;
    end

    lpts_stack #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_urgent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (urg_cmd),
        .i_wdata (entry),
        .o_stat  (urg_stat),
        .o_rdata (urg_rdata)
    );

    lpts_stack #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_background (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (bgd_cmd),
        .i_wdata (entry),
        .o_stat  (bgd_stat),
        .o_rdata (bgd_rdata)
    );

    assign pop_data = (r_sel == PRI_URGENT) ? urg_rdata : bgd_rdata;

    always_comb begin
        if (busy) begin
            t_run = 1'b1;
            t_id  = pop_data[EW-1:DURATION_BITS];
            t_tl  = pop_data[DURATION_BITS-1:0];
        end else begin
            t_run = r_run;
            t_id  = r_cur_id;
            t_tl  = r_ticks;
        end
    end

    always_comb begin
        n_run         = t_run;
        n_tl          = t_tl;
        n_status      = ST_IDLE;
        n_running_id  = '0;
        n_remaining   = '0;
        n_finished    = 1'b0;
        n_finished_id = '0;
        if (!tick_now) begin
            n_status = push_full ? ST_DROPPED : ST_ACCEPTED;
        end else begin
            if (t_run && (t_tl != '0)) begin
                n_tl         = t_tl - DURATION_BITS'(1);
                n_status     = ST_BUSY;
                n_running_id = t_id;
                n_remaining  = n_tl;
            end
            // zero-duration task finishes on the same tick it is loaded
            if (t_run && (n_tl == '0)) begin
                n_finished    = 1'b1;
                n_finished_id = t_id;
                n_run         = 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pop_now) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_run   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (accept && !pop_now) || busy;
            if (tick_now) begin
                r_run <= n_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_now) begin
            r_sel <= urg_stat.empty ? PRI_BACKGROUND : PRI_URGENT;
        end
        if (tick_now) begin
            r_cur_id <= t_id;
            r_ticks  <= n_tl;
        end
        if ((accept && !pop_now) || busy) begin
            o_status      <= n_status;
            o_running_id  <= n_running_id;
            o_remaining   <= n_remaining;
            o_finished    <= n_finished;
            o_finished_id <= n_finished_id;
        end
    end

    a_pop_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy) else $error("pop wait longer than one cycle");
    a_pop_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !r_run) else $error("pop while processor running");
    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid) else $error("popped tick produced no result");
    a_arrive_no_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_status == ST_ACCEPTED) || (o_status == ST_DROPPED)))
        |-> !o_finished) else $error("completion reported on arrive");

endmodule
`default_nettype wire

### src/lpts_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module lpts_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### src/lpts_stack.sv
// lifo stack: fill count plus ram, pop data arrives in the cycle after the pop
`default_nettype none
module lpts_stack #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire lpts_pkg::t_stk_cmd   i_cmd,
    input  wire logic [WIDTH-1:0]     i_wdata,
    output lpts_pkg::t_stk_stat       o_stat,
    output logic      [WIDTH-1:0]     o_rdata
);
    import lpts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] count_m1;

    assign count_m1     = r_count - CW'(1);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = count_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    lpts_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_wdata),
        .i_re    (i_cmd.pop),
        .i_raddr (count_m1[AW-1:0]),
        .o_rdata (o_rdata)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("stack count above depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !o_stat.full) else $error("push onto full stack");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> !o_stat.empty) else $error("pop from empty stack");

endmodule
`default_nettype wire

### bench/two_priority_lifo_task_scheduler_top_test.sv
// testbench for the two-priority lifo task scheduler with a predicting scoreboard
`timescale 1ns / 100ps
`default_nettype none
module two_priority_lifo_task_scheduler_top_test;
    import lpts_pkg::*;

    localparam int DEPTH = 16;
    localparam int ID_W  = 8;
    localparam int DUR_W = 4;
    localparam int RANDOM_ITEMS = 950;
    localparam int QUIET_TAIL   = 150;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  running_id;
        logic [DUR_W-1:0] remaining;
        logic             finished;
        logic [ID_W-1:0]  finished_id;
    } t_sched_report;

    // predicts the scheduler report for every accepted command and checks the outputs
    class t_task_sched_checker;
        logic [ID_W+DUR_W-1:0] urgent_tasks [DEPTH];
        logic [ID_W+DUR_W-1:0] backgr_tasks [DEPTH];
        int unsigned           urgent_n = 0;
        int unsigned           backgr_n = 0;
        bit                    cpu_busy = 0;
        logic [ID_W-1:0]       cur_id = '0;
        logic [DUR_W-1:0]      ticks_left = '0;
        t_sched_report         pending_reports [$];
        int unsigned           errors = 0;

        function void note_command(logic op, logic [ID_W-1:0] id, logic pri,
                                   logic [DUR_W-1:0] dur);
            t_sched_report         r;
            logic [ID_W+DUR_W-1:0] entry;
            bit                    popped;
            r = '0;
            popped = 0;
            entry = {id, dur};
            if (op == OP_ARRIVE) begin
                if (pri == PRI_URGENT) begin
                    if (urgent_n < DEPTH) begin
                        urgent_tasks[urgent_n] = entry;
                        urgent_n++;
                        r.status = ST_ACCEPTED;
                    end else begin
                        r.status = ST_DROPPED;
                    end
                end else begin
                    if (backgr_n < DEPTH) begin
                        backgr_tasks[backgr_n] = entry;
                        backgr_n++;
                        r.status = ST_ACCEPTED;
                    end else begin
                        r.status = ST_DROPPED;
                    end
                end
            end else begin
                if (!cpu_busy) begin
                    if (urgent_n > 0) begin
                        urgent_n--;
                        entry = urgent_tasks[urgent_n];
                        popped = 1;
                    end else if (backgr_n > 0) begin
                        backgr_n--;
                        entry = backgr_tasks[backgr_n];
                        popped = 1;
                    end
                end
                if (popped) begin
                    cur_id = entry[ID_W+DUR_W-1:DUR_W];
                    ticks_left = entry[DUR_W-1:0];
                    cpu_busy = 1;
                end
                if (cpu_busy && ticks_left != 0) begin
                    ticks_left--;
                    r.status = ST_BUSY;
                    r.running_id = cur_id;
                    r.remaining = ticks_left;
                end else begin
                    r.status = ST_IDLE;
                end
                // zero-duration tasks land here on the pop tick itself
                if (cpu_busy && ticks_left == 0) begin
                    r.finished = 1'b1;
                    r.finished_id = cur_id;
                    cpu_busy = 0;
                end
            end
            pending_reports.push_back(r);
        endfunction

        function void check_result(t_sched_report got);
            t_sched_report exp;
            if (pending_reports.size() == 0) begin
                $error("result with no transaction waiting: status %0d", got.status);
                errors++;
                return;
            end
            exp = pending_reports.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.running_id !== exp.running_id) begin
                $error("running_id: expected %0d, actual %0d", exp.running_id, got.running_id);
                errors++;
            end
            if (got.remaining !== exp.remaining) begin
                $error("remaining: expected %0d, actual %0d", exp.remaining, got.remaining);
                errors++;
            end
            if (got.finished !== exp.finished) begin
                $error("finished: expected %0d, actual %0d", exp.finished, got.finished);
                errors++;
            end
            if (got.finished_id !== exp.finished_id) begin
                $error("finished_id: expected %0d, actual %0d", exp.finished_id,
                       got.finished_id);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_reports.size();
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             i_operation = OP_ARRIVE;
    logic [ID_W-1:0]  i_task_id = '0;
    logic             i_priority_req = PRI_URGENT;
    logic [DUR_W-1:0] i_duration = '0;
    logic             o_valid;
    logic [1:0]       o_status;
    logic [ID_W-1:0]  o_running_id;
    logic [DUR_W-1:0] o_remaining;
    logic             o_finished;
    logic [ID_W-1:0]  o_finished_id;

    t_task_sched_checker sched_check = new();
    int unsigned         items_sent = 0;

    two_priority_lifo_task_scheduler_top #(
        .STACK_DEPTH  (DEPTH),
        .ID_BITS      (ID_W),
        .DURATION_BITS(DUR_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_task_id     (i_task_id),
        .i_priority_req(i_priority_req),
        .i_duration    (i_duration),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_running_id  (o_running_id),
        .o_remaining   (o_remaining),
        .o_finished    (o_finished),
        .o_finished_id (o_finished_id)
    );

    always #5 i_clk = ~i_clk;

    // monitor: values read here are the ones before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sched_check.check_result('{o_status, o_running_id, o_remaining, o_finished,
                                       o_finished_id});
        end
        if (i_rst_n && start && !busy) begin
            sched_check.note_command(i_operation, i_task_id, i_priority_req, i_duration);
        end
    end

    function automatic int pick_gap(bit quiet);
        if (quiet || $urandom_range(0, 3) != 0) return 0;
        return $urandom_range(1, 19);
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int sel;
        sel = $urandom_range(0, 39);
        if (sel == 0) return '0;
        if (sel < 8) return DUR_W'($urandom_range(1, 15));
        return DUR_W'($urandom_range(1, 4));
    endfunction

    // presents one command and returns at the edge where it is taken
    task automatic send_command(logic op, logic [ID_W-1:0] id, logic pri,
                                logic [DUR_W-1:0] dur, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_task_id <= id;
        i_priority_req <= pri;
        i_duration <= dur;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    task automatic send_tick(int gap);
        send_command(OP_TICK, ID_W'($urandom), 1'($urandom), DUR_W'($urandom), gap);
    endtask

    task automatic send_arrive(logic pri, int gap);
        send_command(OP_ARRIVE, ID_W'($urandom_range(0, 255)), pri, pick_duration(), gap);
    endtask

    initial begin
        int  kind;
        int  n;
        int  pct;
        bit  quiet;
        logic pri;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle on empty, zero duration, lifo order, priority order
        send_tick(0);
        send_command(OP_ARRIVE, 8'h00, PRI_BACKGROUND, 4'd0, 0);
        send_tick(0);
        send_tick(0);
        send_command(OP_ARRIVE, 8'hAA, PRI_BACKGROUND, 4'd2, 0);
        send_command(OP_ARRIVE, 8'hFF, PRI_URGENT, 4'd1, 0);
        send_command(OP_ARRIVE, 8'h55, PRI_URGENT, 4'd3, 2);
        repeat (7) send_tick(pick_gap(0));
        send_command(OP_ARRIVE, 8'h00, PRI_URGENT, 4'd15, 0);
        send_command(OP_ARRIVE, 8'hFF, PRI_BACKGROUND, 4'd15, 0);
        send_tick(0);
        send_tick(0);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            quiet = (items_sent >= RANDOM_ITEMS - QUIET_TAIL) || ($urandom_range(0, 4) == 0);
            if (kind < 2) begin
                // burst into one class, long enough to overflow it
                pri = 1'($urandom_range(0, 1));
                n = $urandom_range(17, 20);
                repeat (n) send_arrive(pri, pick_gap(quiet));
            end else if (kind < 4) begin
                n = $urandom_range(30, 60);
                repeat (n) send_tick(pick_gap(quiet));
            end else begin
                n = $urandom_range(20, 40);
                pct = $urandom_range(20, 80);
                repeat (n) begin
                    if ($urandom_range(0, 99) < pct)
                        send_arrive(1'($urandom_range(0, 1)), pick_gap(quiet));
                    else
                        send_tick(pick_gap(quiet));
                end
            end
        end
        start <= 1'b0;

        while (sched_check.outstanding() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sched_check.errors == 0 && sched_check.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
